// ===== rtl/wcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wcr_pkg;

    localparam int RANK_W    = 34;
    localparam int COUNT_W   = 7;
    localparam int CFG_W     = 4;
    localparam int TOTAL_W   = 10;

    localparam logic [TOTAL_W-1:0] TOTAL_SAT  = '1;
    localparam logic [CFG_W-1:0]   CFG_RESET  = 4'd2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETUP,
        ST_SWEEP,
        ST_FOLD,
        ST_OUT
    } wcr_state_t;

    typedef struct packed {
        logic cfg;
        logic load;
        logic start;
        logic setup;
        logic sweep;
        logic fold;
        logic out_load;
    } wcr_cmd_t;

    typedef struct packed {
        logic last;
        logic big;
        logic idx_last;
        logic sweep_last;
    } wcr_status_t;

endpackage

`default_nettype wire

// ===== rtl/weak_composition_rank_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Ranks a vector of part counts among all weak compositions with the configured
// number of parts m, ordered by total and then by ascending leading values.
// Counts arrive one beat per cycle on s_ while loading and no cfg write is
// pending; after the m-th beat the rank appears on m_ (rank 0 with
// total_too_large set when the sum exceeds MAX_TOTAL). Writing num_parts
// discards a partly loaded vector. An item is loaded, set up per position, then
// swept through Pascal's triangle one row per cycle; the per-position sums are
// folded and the output register is loaded. An oversized total skips from setup
// straight to the output. The sweep of rows dominates. The output
// register holds a result while the next vector loads.

module weak_composition_rank_unit import wcr_pkg::*; #(
    parameter int MAX_PARTS = 8,
    parameter int MAX_TOTAL = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CFG_W-1:0]   cfg_num_parts,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [COUNT_W-1:0] s_part_count,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [RANK_W-1:0]       m_rank,
    output logic                    m_total_too_large
);

    wcr_cmd_t    cmd;
    wcr_status_t status;

    wcr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .status    (status)
    );

    wcr_datapath #(
        .MAX_PARTS (MAX_PARTS),
        .MAX_TOTAL (MAX_TOTAL)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_num_parts   (cfg_num_parts),
        .part_count      (s_part_count),
        .rank            (m_rank),
        .total_too_large (m_total_too_large)
    );

endmodule

`default_nettype wire

// ===== rtl/wcr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wcr_ctrl import wcr_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    output wcr_cmd_t         cmd,
    input  wire wcr_status_t status
);

    wcr_state_t state_reg;
    wcr_state_t state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        cfg_ready  = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                cfg_ready = 1'b1;
                s_ready   = !cfg_valid;
                cmd.cfg   = cfg_valid;
                cmd.load  = s_valid && !cfg_valid;
                if (s_valid && !cfg_valid && status.last) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (status.big) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.setup = 1'b1;
                    if (status.idx_last) begin
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP: begin
                cmd.sweep = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                cmd.fold = 1'b1;
                if (status.idx_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        priority if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/wcr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wcr_datapath import wcr_pkg::*; #(
    parameter int MAX_PARTS = 8,
    parameter int MAX_TOTAL = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire wcr_cmd_t           cmd,
    output wcr_status_t             status,
    input  wire logic [CFG_W-1:0]   cfg_num_parts,
    input  wire logic [COUNT_W-1:0] part_count,
    output logic [RANK_W-1:0]       rank,
    output logic                    total_too_large
);

    localparam int CW  = $clog2(MAX_PARTS + 1);
    localparam int CW1 = CW + 1;
    localparam int IW  = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int NW  = $clog2(MAX_TOTAL + MAX_PARTS);
    localparam int TW1 = TOTAL_W + 1;

    logic [CFG_W-1:0]   num_parts_reg;
    logic [CW-1:0]      loaded_reg;
    logic [TOTAL_W-1:0] total_reg;

    logic [COUNT_W-1:0] count_store [MAX_PARTS];
    logic [COUNT_W-1:0] count_rd_reg;

    logic               big_reg;
    logic [NW-1:0]      left_reg;
    logic [NW-1:0]      head_n_reg;
    logic [NW-1:0]      row_n_reg;
    logic [IW-1:0]      idx_reg;
    logic [RANK_W-1:0]  acc_reg;
    logic [RANK_W-1:0]  rank_reg;
    logic               flag_reg;

    logic [RANK_W-1:0]  row_reg      [0:MAX_PARTS];
    logic [RANK_W-1:0]  row_next     [0:MAX_PARTS];
    logic [NW-1:0]      np_reg       [MAX_PARTS];
    logic [NW-1:0]      nm_reg       [MAX_PARTS];
    logic [CW-1:0]      k_reg        [MAX_PARTS];
    logic [RANK_W-1:0]  lane_acc_reg [MAX_PARTS];
    logic [RANK_W-1:0]  lane_next    [MAX_PARTS];

    logic [CW-1:0]      eff_m;
    logic [TW1-1:0]     sum_ext;
    logic [TOTAL_W-1:0] total_new;
    logic [TOTAL_W-1:0] cnt_ext;
    logic [TOTAL_W-1:0] left_ext;
    logic [TOTAL_W-1:0] take;
    logic [NW-1:0]      take_n;
    logic [CW-1:0]      rem;
    logic [NW-1:0]      np_new;
    logic [NW-1:0]      nm_new;
    logic [RANK_W-1:0]  head_term;

    // effective part count: zero acts as one, clipped to MAX_PARTS
    always_comb begin
        priority if (num_parts_reg == '0) begin
            eff_m = CW'(1);
        end else if (num_parts_reg > MAX_PARTS) begin
            eff_m = CW'(MAX_PARTS);
        end else begin
            eff_m = CW'(num_parts_reg);
        end
    end

    assign sum_ext   = TW1'(total_reg) + TW1'(part_count);
    assign total_new = (sum_ext > TW1'(TOTAL_SAT)) ? TOTAL_SAT : sum_ext[TOTAL_W-1:0];

    // one position per cycle: clamp the count to what is left of the total
    assign cnt_ext  = TOTAL_W'(count_rd_reg);
    assign left_ext = TOTAL_W'(left_reg);
    assign take     = (cnt_ext > left_ext) ? left_ext : cnt_ext;
    assign take_n   = NW'(take);
    assign rem      = eff_m - CW'(1) - CW'(idx_reg);
    assign np_new   = left_reg + NW'(rem);
    assign nm_new   = left_reg - take_n + NW'(rem);

    // Pascal row update and per-position hockey-stick differences
    always_comb begin
        row_next[0] = row_reg[0];
        for (int k = 1; k <= MAX_PARTS; k++) begin
            row_next[k] = row_reg[k] + row_reg[k-1];
        end
    end

    always_comb begin
        logic [RANK_W-1:0] term;
        logic [RANK_W-1:0] plus;
        logic [RANK_W-1:0] minus;
        for (int p = 0; p < MAX_PARTS; p++) begin
            term  = (k_reg[p] <= MAX_PARTS) ? row_reg[k_reg[p]] : '0;
            plus  = (row_n_reg == np_reg[p]) ? term : '0;
            minus = (row_n_reg == nm_reg[p]) ? term : '0;
            lane_next[p] = lane_acc_reg[p] + plus - minus;
        end
    end

    assign head_term = (row_n_reg == head_n_reg) ? row_reg[eff_m] : '0;

    assign status.last       = (CW1'(loaded_reg) + CW1'(1)) == CW1'(eff_m);
    assign status.big        = big_reg;
    assign status.idx_last   = CW'(idx_reg) == (eff_m - CW'(1));
    assign status.sweep_last = row_n_reg == head_n_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_parts_reg <= CFG_RESET;
            loaded_reg    <= '0;
            total_reg     <= '0;
        end else if (cmd.cfg) begin
            num_parts_reg <= cfg_num_parts;
            loaded_reg    <= '0;
            total_reg     <= '0;
        end else if (cmd.load) begin
            if (cmd.start) begin
                loaded_reg <= '0;
                total_reg  <= '0;
            end else begin
                loaded_reg <= loaded_reg + CW'(1);
                total_reg  <= total_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            count_store[loaded_reg[IW-1:0]] <= part_count;
        end
        if (cmd.start) begin
            // first entry may be the beat arriving now
            count_rd_reg <= (loaded_reg == '0) ? part_count : count_store[IW'(0)];
            big_reg    <= total_new > TOTAL_W'(MAX_TOTAL);
            left_reg   <= NW'(total_new);
            head_n_reg <= NW'(total_new) + NW'(eff_m) - NW'(1);
            idx_reg    <= '0;
            row_n_reg  <= '0;
            acc_reg    <= '0;
            for (int k = 0; k <= MAX_PARTS; k++) begin
                row_reg[k] <= (k == 0) ? RANK_W'(1) : '0;
            end
            for (int p = 0; p < MAX_PARTS; p++) begin
                lane_acc_reg[p] <= '0;
            end
        end else if (cmd.setup) begin
            count_rd_reg    <= count_store[idx_reg + IW'(1)];
            np_reg[idx_reg] <= np_new;
            nm_reg[idx_reg] <= nm_new;
            k_reg[idx_reg]  <= rem;
            left_reg        <= left_reg - take_n;
            idx_reg         <= idx_reg + IW'(1);
        end else if (cmd.sweep) begin
            row_reg      <= row_next;
            lane_acc_reg <= lane_next;
            row_n_reg    <= row_n_reg + NW'(1);
            acc_reg      <= acc_reg + head_term;
            if (status.sweep_last) begin
                idx_reg <= '0;
            end
        end else if (cmd.fold) begin
            acc_reg <= acc_reg + lane_acc_reg[idx_reg];
            idx_reg <= idx_reg + IW'(1);
        end
        if (cmd.out_load) begin
            rank_reg <= big_reg ? '0 : acc_reg;
            flag_reg <= big_reg;
        end
    end

    assign rank            = rank_reg;
    assign total_too_large = flag_reg;

endmodule

`default_nettype wire

// ===== test/weak_composition_rank_checker.sv =====
`timescale 1ns / 1ps

module weak_composition_rank_checker import wcr_pkg::*; #(
    parameter int MAX_PARTS = 8,
    parameter int MAX_TOTAL = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [CFG_W-1:0]   cfg_num_parts,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [COUNT_W-1:0] s_part_count,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [RANK_W-1:0]  m_rank,
    input  logic               m_total_too_large,
    output int                 mismatches,
    output int                 ranks_pending
);

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              too_large;
    } rank_beat_t;

    rank_beat_t         expected_ranks[$];
    logic [COUNT_W-1:0] part_counts[MAX_PARTS];
    logic [CFG_W-1:0]   parts_cfg;
    int unsigned        parts_loaded;
    logic [TOTAL_W-1:0] count_sum;

    // weak compositions of s into m parts, C(s+m-1, m-1), each step divides exactly
    function automatic longint unsigned compositions(int unsigned s, int unsigned m);
        longint unsigned c;
        int unsigned     n, k, i;
        c = 1;
        n = s + m - 1;
        k = m - 1;
        if (k > n - k) k = n - k;
        for (i = 1; i <= k; i++) c = c * (n - k + i) / i;
        return c;
    endfunction

    function automatic logic [RANK_W-1:0] graded_rank(int unsigned m, int unsigned total);
        longint unsigned r;
        int unsigned     left, v, s, p, j;
        r = 0;
        left = total;
        for (s = 0; s < total; s++) r += compositions(s, m);
        for (p = 0; p < m && left != 0; p++) begin
            v = part_counts[p];
            if (v > left) v = left;
            if (p != m - 1)
                for (j = 0; j < v; j++) r += compositions(left - j, m - 1 - p);
            left -= v;
        end
        return r[RANK_W-1:0];
    endfunction

    always @(posedge aclk) begin
        int unsigned eff, sum;
        rank_beat_t  want;
        if (!aresetn) begin
            expected_ranks.delete();
            parts_cfg = CFG_RESET;
            parts_loaded = 0;
            count_sum = '0;
            mismatches = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_ranks.size() == 0) begin
                    $error("rank: no beat expected, actual %0d", m_rank);
                    mismatches++;
                end else begin
                    want = expected_ranks.pop_front();
                    if (m_rank !== want.rank) begin
                        $error("rank: expected %0d, actual %0d", want.rank, m_rank);
                        mismatches++;
                    end
                    if (m_total_too_large !== want.too_large) begin
                        $error("total_too_large: expected %0b, actual %0b",
                               want.too_large, m_total_too_large);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                parts_cfg = cfg_num_parts;
                parts_loaded = 0;
                count_sum = '0;
            end
            if (s_valid && s_ready) begin
                if (parts_loaded < MAX_PARTS) part_counts[parts_loaded] = s_part_count;
                sum = count_sum + s_part_count;
                count_sum = (sum > TOTAL_SAT) ? TOTAL_SAT : sum[TOTAL_W-1:0];
                parts_loaded++;
                eff = (parts_cfg == 0) ? 1 : ((parts_cfg > MAX_PARTS) ? MAX_PARTS : parts_cfg);
                if (parts_loaded >= eff) begin
                    want.too_large = (count_sum > MAX_TOTAL);
                    want.rank = want.too_large ? '0 : graded_rank(eff, count_sum);
                    expected_ranks.push_back(want);
                    parts_loaded = 0;
                    count_sum = '0;
                end
            end
        end
        ranks_pending = expected_ranks.size();
    end

endmodule

// ===== test/tb_weak_composition_rank_unit.sv =====
`timescale 1ns / 1ps

module tb_weak_composition_rank_unit;
    import wcr_pkg::*;

    localparam int     MAX_PARTS     = 8;
    localparam int     MAX_TOTAL     = 64;
    localparam int     ITEM_TARGET   = 950;
    localparam int     SETTLE_CYCLES = 200;
    localparam longint CYCLE_LIMIT   = 1000000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_num_parts = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [COUNT_W-1:0] s_part_count = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [RANK_W-1:0]  m_rank;
    logic               m_total_too_large;

    int     mismatches;
    int     ranks_pending;
    int     items_sent = 0;
    bit     s_steady = 1'b0;
    bit     m_steady = 1'b0;
    longint cycles = 0;

    always #2 aclk = ~aclk;

    weak_composition_rank_unit #(
        .MAX_PARTS(MAX_PARTS),
        .MAX_TOTAL(MAX_TOTAL)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_num_parts(cfg_num_parts),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_part_count(s_part_count),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_rank(m_rank),
        .m_total_too_large(m_total_too_large)
    );

    weak_composition_rank_checker #(
        .MAX_PARTS(MAX_PARTS),
        .MAX_TOTAL(MAX_TOTAL)
    ) rank_check (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_num_parts(cfg_num_parts),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_part_count(s_part_count),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_rank(m_rank),
        .m_total_too_large(m_total_too_large),
        .mismatches(mismatches),
        .ranks_pending(ranks_pending)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: random stall before each beat unless m_steady
    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            stall = m_steady ? 0 : $urandom_range(0, 12);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    task automatic send_count(input logic [COUNT_W-1:0] value);
        int gap;
        gap = s_steady ? 0 : $urandom_range(0, 12);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_part_count <= value;
        do @(posedge aclk); while (!(s_valid && s_ready));
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (ranks_pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_parts(input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_num_parts <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [COUNT_W-1:0] pair_counts[12] = '{0, 0, 64, 0, 0, 64, 33, 31, 40, 25, 127, 127};
        logic [COUNT_W-1:0] extremes[3] = '{0, 64, 127};
        logic [CFG_W-1:0]   lead_parts[6] = '{1, 8, 0, 15, 4, 9};
        logic [CFG_W-1:0]   parts;
        int unsigned        m, n_vec, vi, p, mode, budget, v;
        int                 phase;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset value of two parts: zero vector, totals at and above the limit
        foreach (pair_counts[i]) send_count(pair_counts[i]);
        wait_idle();
        // zero parts behaves as one
        write_parts(4'd0);
        send_count(0);
        send_count(64);
        send_count(65);
        wait_idle();
        // above the maximum behaves as the maximum
        write_parts(4'd15);
        repeat (8) send_count(8);
        wait_idle();
        // partial vector, dropped by the next register write
        write_parts(4'd3);
        send_count(5);
        send_count(127);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            parts = (phase < 6) ? lead_parts[phase] : CFG_W'($urandom_range(0, 15));
            write_parts(parts);
            m = (parts == 0) ? 1 : ((parts > MAX_PARTS) ? MAX_PARTS : parts);
            s_steady = ($urandom_range(0, 3) == 0);
            m_steady = ($urandom_range(0, 3) == 0);
            n_vec = $urandom_range(4, 20);
            for (vi = 0; vi < n_vec; vi++) begin
                mode = $urandom_range(0, 9);
                budget = (mode == 6) ? 64 + $urandom_range(0, 1) : $urandom_range(0, 64);
                for (p = 0; p < m; p++) begin
                    if (mode == 7)
                        v = $urandom_range(0, 127);
                    else if (mode == 8)
                        v = $urandom_range(0, 3);
                    else if (mode == 9)
                        v = extremes[$urandom_range(0, 2)];
                    else if (mode == 6 && p == m - 1)
                        v = budget;
                    else
                        v = $urandom_range(0, budget / $urandom_range(1, 3));
                    if (mode < 7) budget -= v;
                    send_count(COUNT_W'(v));
                end
            end
            if (m > 1 && $urandom_range(0, 3) == 0)
                for (p = $urandom_range(1, m - 1); p > 0; p--)
                    send_count(COUNT_W'($urandom_range(0, 127)));
            phase++;
        end

        wait_idle();
        if (mismatches == 0 && ranks_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== weak_composition_rank_unit.f =====
rtl/wcr_pkg.sv
rtl/wcr_ctrl.sv
rtl/wcr_datapath.sv
rtl/weak_composition_rank_unit.sv
test/weak_composition_rank_checker.sv
test/tb_weak_composition_rank_unit.sv
